@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, inactive while reset is asserted.
`define TPFC_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property, also checked through reset.
`define TPFC_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tpfc_pkg.sv @@
// Types, constants and CRC function for the transponder page frame check.
`timescale 1ns / 1ps

package tpfc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8408;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_DIAG_ZERO = 2'd1;
    localparam logic [1:0] STATUS_START_ZERO = 2'd2;
    localparam logic [1:0] STATUS_CRC_BAD   = 2'd3;

    localparam logic [3:0] POS_DIAG   = 4'd0;
    localparam logic [3:0] POS_START  = 4'd1;
    localparam logic [3:0] POS_DATA0  = 4'd2;
    localparam logic [3:0] POS_DATA7  = 4'd9;
    localparam logic [3:0] POS_CRC_LO = 4'd10;
    localparam logic [3:0] POS_CRC_HI = 4'd11;

    localparam int DATA_BYTES = 8;
    localparam int DATA_AW    = 3;

    typedef struct packed {
        logic               crc_clr;
        logic               page_ld;
        logic               data_wr;
        logic [DATA_AW-1:0] wr_addr;
        logic               crc_low_ld;
        logic               load_fail;
        logic [1:0]         fail_status;
        logic               load_data;
        logic               last;
        logic [DATA_AW-1:0] emit_idx;
        logic [DATA_AW-1:0] rd_addr;
    } tpfc_cmd_t;

    typedef struct packed {
        logic rx_zero;
        logic crc_match;
        logic out_free;
    } tpfc_sts_t;

    // Reflected CRC-16, one byte.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/tpfc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tpfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tpfc_datapath.sv @@
// Datapath: CRC accumulator, page and CRC byte registers, data store and result register.
`timescale 1ns / 1ps

module tpfc_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         rx_byte,
    input  logic [1:0]         page_number,
    input  tpfc_pkg::tpfc_cmd_t cmd,
    output tpfc_pkg::tpfc_sts_t sts,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [3:0]         m_tag_index,
    output logic [7:0]         m_tag_byte,
    output logic [1:0]         m_status,
    output logic               m_last
);
    import tpfc_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [1:0]  page_reg;
    logic [7:0]  crc_low_reg;
    logic [7:0]  inv_byte;
    logic [7:0]  rd_data;

    logic       valid_reg, valid_next;
    logic [3:0] index_reg;
    logic [7:0] byte_reg;
    logic [1:0] status_reg;
    logic       last_reg;

    assign inv_byte = ~rx_byte;

    assign sts.rx_zero   = (rx_byte == 8'h00);
    assign sts.crc_match = (crc_reg[7:0] == crc_low_reg) && (crc_reg[15:8] == inv_byte);
    assign sts.out_free  = !valid_reg || m_ready;

    always_comb begin
        crc_next = crc_reg;
        if (cmd.crc_clr) begin
            crc_next = 16'h0000;
        end else if (cmd.data_wr) begin
            crc_next = crc_feed(crc_reg, inv_byte);
        end
    end

    tpfc_ram #(
        .WIDTH(8),
        .DEPTH(DATA_BYTES)
    ) u_store (
        .aclk (aclk),
        .we   (cmd.data_wr),
        .waddr(cmd.wr_addr),
        .wdata(inv_byte),
        .raddr(cmd.rd_addr),
        .rdata(rd_data)
    );

    always_comb begin
        valid_next = valid_reg;
        if (cmd.load_fail || cmd.load_data) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= 16'h0000;
            page_reg  <= 2'd1;
            valid_reg <= 1'b0;
        end else begin
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
            if (cmd.page_ld) begin
                page_reg <= page_number;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.crc_low_ld) begin
            crc_low_reg <= inv_byte;
        end
        if (cmd.load_fail) begin
            index_reg  <= 4'd0;
            byte_reg   <= 8'h00;
            status_reg <= cmd.fail_status;
            last_reg   <= 1'b1;
        end else if (cmd.load_data) begin
            // 7 - n + 8 * (page - 1), modulo 16
            index_reg  <= {~page_reg[0], ~cmd.emit_idx};
            byte_reg   <= rd_data;
            status_reg <= STATUS_OK;
            last_reg   <= cmd.last;
        end
    end

    assign m_valid     = valid_reg;
    assign m_tag_index = index_reg;
    assign m_tag_byte  = byte_reg;
    assign m_status    = status_reg;
    assign m_last      = last_reg;

endmodule

@@ rtl/tpfc_ctrl.sv @@
// Controller: byte position sequencing, abort handling and result emission.
`timescale 1ns / 1ps

module tpfc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                frame_start,
    output logic                s_ready,
    output tpfc_pkg::tpfc_cmd_t cmd,
    input  tpfc_pkg::tpfc_sts_t sts
);
    import tpfc_pkg::*;

    typedef enum logic {
        ST_RUN,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [3:0]         pos_reg, pos_next;
    logic               aborted_reg, aborted_next;
    logic [DATA_AW-1:0] n_reg, n_next;

    logic       accept;
    logic [3:0] pos_eff;
    logic       aborted_eff;

    assign s_ready     = (state_reg == ST_RUN) && sts.out_free;
    assign accept      = s_valid && s_ready;
    assign pos_eff     = frame_start ? POS_DIAG : pos_reg;
    assign aborted_eff = frame_start ? 1'b0 : aborted_reg;

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        aborted_next = aborted_reg;
        n_next       = n_reg;
        cmd          = '0;
        cmd.wr_addr  = DATA_AW'(pos_eff - POS_DATA0);
        cmd.emit_idx = n_reg;

        case (state_reg)
            ST_RUN: begin
                if (accept) begin
                    cmd.crc_clr = frame_start;
                    cmd.page_ld = frame_start;
                    if (frame_start) begin
                        aborted_next = 1'b0;
                        pos_next     = POS_DIAG;
                    end
                    if (!aborted_eff) begin
                        if (pos_eff == POS_DIAG) begin
                            if (sts.rx_zero) begin
                                aborted_next    = 1'b1;
                                cmd.load_fail   = 1'b1;
                                cmd.fail_status = STATUS_DIAG_ZERO;
                            end else begin
                                pos_next = POS_START;
                            end
                        end else if (pos_eff == POS_START) begin
                            if (sts.rx_zero) begin
                                aborted_next    = 1'b1;
                                cmd.load_fail   = 1'b1;
                                cmd.fail_status = STATUS_START_ZERO;
                            end else begin
                                pos_next = POS_DATA0;
                            end
                        end else if (pos_eff inside {[POS_DATA0:POS_DATA7]}) begin
                            cmd.data_wr = 1'b1;
                            pos_next    = pos_eff + 4'd1;
                        end else if (pos_eff == POS_CRC_LO) begin
                            cmd.crc_low_ld = 1'b1;
                            pos_next       = POS_CRC_HI;
                        end else begin
                            aborted_next = 1'b1;
                            pos_next     = POS_DIAG;
                            if (pos_eff == POS_CRC_HI && sts.crc_match) begin
                                state_next = ST_EMIT;
                                n_next     = '0;
                            end else begin
                                cmd.load_fail   = 1'b1;
                                cmd.fail_status = STATUS_CRC_BAD;
                            end
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.load_data = 1'b1;
                    cmd.last      = (n_reg == DATA_AW'(DATA_BYTES - 1));
                    n_next        = n_reg + 1'b1;
                    if (n_reg == DATA_AW'(DATA_BYTES - 1)) begin
                        state_next = ST_RUN;
                        n_next     = '0;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase

        cmd.rd_addr = n_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            pos_reg     <= POS_DIAG;
            aborted_reg <= 1'b1;
            n_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            aborted_reg <= aborted_next;
            n_reg       <= n_next;
        end
    end

endmodule

@@ rtl/transponder_page_frame_check_core.sv @@
// Top level of the transponder page frame check: controller plus datapath.
// A failure item is presented in the cycle after its byte. Ok page: after the last CRC byte
// the controller enters its emit state and sends the 8 data items from the data store read
// port, one item per cycle while the result register is free; input waits meanwhile.
// Throughput: one byte per cycle while no page is emitted and the result register is free.
// Reset (aresetn low, synchronous) clears control state; the data store is not cleared.
`timescale 1ns / 1ps

module transponder_page_frame_check_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic [1:0] s_page_number,
    input  logic       s_frame_start,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_tag_index,
    output logic [7:0] m_tag_byte,
    output logic [1:0] m_status,
    output logic       m_last
);
    import tpfc_pkg::*;

    tpfc_cmd_t cmd;
    tpfc_sts_t sts;

    tpfc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .frame_start(s_frame_start),
        .s_ready    (s_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    tpfc_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rx_byte    (s_rx_byte),
        .page_number(s_page_number),
        .cmd        (cmd),
        .sts        (sts),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_tag_index(m_tag_index),
        .m_tag_byte (m_tag_byte),
        .m_status   (m_status),
        .m_last     (m_last)
    );

endmodule

@@ rtl/tpfc_checker.sv @@
// Port-level checker for the transponder page frame check, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpfc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_tag_index,
    input logic [7:0] m_tag_byte,
    input logic [1:0] m_status,
    input logic       m_last
);
    import tpfc_pkg::*;

    `TPFC_ASSERT_CLK(a_no_valid_after_reset, aclk, !aresetn |=> !m_valid, "item valid after reset")
    `TPFC_ASSERT_RST(a_valid_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid, "item dropped")
    `TPFC_ASSERT_RST(a_fail_is_last, aclk, aresetn, m_valid && m_status != STATUS_OK |-> m_last, "failure item not last")
    `TPFC_ASSERT_RST(a_fail_zero, aclk, aresetn, m_valid && m_status != STATUS_OK |-> m_tag_index == 4'd0 && m_tag_byte == 8'h00, "failure item payload not zero")

endmodule

bind transponder_page_frame_check_core tpfc_checker u_tpfc_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_tag_index(m_tag_index),
    .m_tag_byte (m_tag_byte),
    .m_status   (m_status),
    .m_last     (m_last)
);
